/* rtl/core/lmsa_pkg.sv */
// ============================================================================
// lmsa_pkg: shared types, codes and tables of the LED sign animator
// Holds the input and result word layouts, the action, command and register
// codes, the 5x7 glyph table and the lookup of the three glyphs per picture.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package lmsa_pkg;

    localparam int ROW_COUNT  = 7;
    localparam int ROW_W      = 3;
    localparam int GLYPH_W    = 5;
    localparam int FRAME_W    = 3 * GLYPH_W;
    localparam int BRIGHT_W   = 14;
    localparam int STEP_W     = 16;
    localparam int TOTAL_W    = STEP_W + 1;

    localparam logic [BRIGHT_W-1:0] BRIGHT_MAX   = 14'd10000;
    localparam logic [BRIGHT_W-1:0] BRIGHT_RESET = 14'd5000;
    localparam logic [STEP_W-1:0]   TURN_RESET   = 16'd250;
    localparam logic [STEP_W-1:0]   HAZARD_RESET = 16'd500;
    localparam logic [STEP_W-1:0]   WIPER_RESET  = 16'd250;

    // Actions carried by an input word.
    localparam logic [1:0] ACT_SET     = 2'd0;
    localparam logic [1:0] ACT_ADVANCE = 2'd1;
    localparam logic [1:0] ACT_READ    = 2'd2;

    // Lamp commands.
    localparam logic [3:0] CMD_OFF    = 4'd0;
    localparam logic [3:0] CMD_LEFT   = 4'd1;
    localparam logic [3:0] CMD_RIGHT  = 4'd2;
    localparam logic [3:0] CMD_HIGH   = 4'd3;
    localparam logic [3:0] CMD_LOW    = 4'd4;
    localparam logic [3:0] CMD_FOG    = 4'd5;
    localparam logic [3:0] CMD_HAZARD = 4'd6;
    localparam logic [3:0] CMD_CABIN  = 4'd7;
    localparam logic [3:0] CMD_WIPER  = 4'd8;
    localparam logic [3:0] CMD_LIMIT  = 4'd9;

    // Configuration register indexes.
    localparam logic [1:0] REG_BRIGHT = 2'd0;
    localparam logic [1:0] REG_TURN   = 2'd1;
    localparam logic [1:0] REG_HAZARD = 2'd2;
    localparam logic [1:0] REG_WIPER  = 2'd3;

    // Glyph ids.
    localparam logic [4:0] G_SP   = 5'd0;
    localparam logic [4:0] G_BANG = 5'd1;
    localparam logic [4:0] G_SL   = 5'd2;
    localparam logic [4:0] G_BS   = 5'd3;
    localparam logic [4:0] G_BAR  = 5'd4;
    localparam logic [4:0] G_LT   = 5'd5;
    localparam logic [4:0] G_GT   = 5'd6;
    localparam logic [4:0] G_A    = 5'd7;
    localparam logic [4:0] G_B    = 5'd8;
    localparam logic [4:0] G_C    = 5'd9;
    localparam logic [4:0] G_F    = 5'd10;
    localparam logic [4:0] G_G    = 5'd11;
    localparam logic [4:0] G_H    = 5'd12;
    localparam logic [4:0] G_I    = 5'd13;
    localparam logic [4:0] G_L    = 5'd14;
    localparam logic [4:0] G_O    = 5'd15;
    localparam logic [4:0] G_W    = 5'd16;

    typedef logic [4:0] glyph_id_t;

    typedef struct packed {
        logic [1:0]  action;
        logic [3:0]  lamp_command;
        logic [15:0] delta_ms;
        logic [2:0]  row_index;
    } item_t;

    typedef struct packed {
        logic [14:0] row_bits;
        logic [3:0]  current_command;
        logic [1:0]  current_phase;
        logic        frame_changed;
        logic [13:0] brightness_out;
    } result_t;

    // Result of one run of the serial divider.
    typedef struct packed {
        logic              done;
        logic [1:0]        quot_lo;
        logic [STEP_W-1:0] rem;
    } div_res_t;

    // 5x7 glyph rows; bit 4 is the leftmost column.
    localparam logic [GLYPH_W-1:0] GLYPH_ROM [0:16][0:ROW_COUNT-1] = '{
        '{5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00},
        '{5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h00, 5'h04},
        '{5'h01, 5'h02, 5'h02, 5'h04, 5'h08, 5'h08, 5'h10},
        '{5'h10, 5'h08, 5'h08, 5'h04, 5'h02, 5'h02, 5'h01},
        '{5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04},
        '{5'h02, 5'h04, 5'h08, 5'h10, 5'h08, 5'h04, 5'h02},
        '{5'h08, 5'h04, 5'h02, 5'h01, 5'h02, 5'h04, 5'h08},
        '{5'h0E, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11},
        '{5'h1E, 5'h11, 5'h11, 5'h1E, 5'h11, 5'h11, 5'h1E},
        '{5'h0E, 5'h11, 5'h10, 5'h10, 5'h10, 5'h11, 5'h0E},
        '{5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h10},
        '{5'h0E, 5'h11, 5'h10, 5'h17, 5'h11, 5'h11, 5'h0E},
        '{5'h11, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11},
        '{5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h1F},
        '{5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h1F},
        '{5'h0E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E},
        '{5'h11, 5'h11, 5'h11, 5'h15, 5'h15, 5'h15, 5'h0A}
    };

    // Three glyph ids, left first, for a command and phase.
    function automatic logic [14:0] pick_glyphs(input logic [3:0] cmd, input logic [1:0] ph);
        logic [14:0] g;
        g = {G_SP, G_SP, G_SP};
        unique case (cmd)
            CMD_LEFT:
            begin
                unique case (ph)
                    2'd0:    g = {G_SP, G_SP, G_LT};
                    2'd1:    g = {G_SP, G_LT, G_LT};
                    2'd2:    g = {G_LT, G_LT, G_LT};
                    default: g = {G_SP, G_SP, G_SP};
                endcase
            end
            CMD_RIGHT:
            begin
                unique case (ph)
                    2'd0:    g = {G_GT, G_SP, G_SP};
                    2'd1:    g = {G_GT, G_GT, G_SP};
                    2'd2:    g = {G_GT, G_GT, G_GT};
                    default: g = {G_SP, G_SP, G_SP};
                endcase
            end
            CMD_HIGH:   g = {G_H, G_I, G_G};
            CMD_LOW:    g = {G_L, G_O, G_W};
            CMD_FOG:    g = {G_F, G_O, G_G};
            CMD_HAZARD: g = (ph == 2'd0) ? {G_BANG, G_BANG, G_BANG} : {G_SP, G_SP, G_SP};
            CMD_CABIN:  g = {G_C, G_A, G_B};
            CMD_WIPER:
            begin
                unique case (ph)
                    2'd0:    g = {G_SL, G_SL, G_SL};
                    2'd2:    g = {G_BS, G_BS, G_BS};
                    default: g = {G_BAR, G_BAR, G_BAR};
                endcase
            end
            default:    g = {G_SP, G_SP, G_SP};
        endcase
        return g;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/lmsa_div.sv */
// ============================================================================
// lmsa_div: serial divider for the phase advance
// Restoring division of a 17-bit time total by a 16-bit step period, one
// quotient bit per cycle. Keeps the remainder and the two lowest quotient bits.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module lmsa_div (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic [lmsa_pkg::TOTAL_W-1:0] dividend,
    input  wire logic [lmsa_pkg::STEP_W-1:0]  divisor,
    output lmsa_pkg::div_res_t              res
);
    import lmsa_pkg::*;

    localparam int CNT_W = $clog2(TOTAL_W + 1);

    logic              busy_reg;
    logic              done_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [TOTAL_W-1:0] dvd_reg;
    logic [STEP_W-1:0] dsr_reg;
    logic [STEP_W-1:0] rem_reg;
    logic [STEP_W-1:0] rem_next;
    logic [1:0]        q_reg;
    logic [TOTAL_W-1:0] shifted;
    logic [TOTAL_W:0]   diff;
    logic              q_bit;

    // One restoring step: bring in the next dividend bit and try a subtract.
    always_comb
    begin
        shifted = {rem_reg, dvd_reg[TOTAL_W-1]};
        diff    = {1'b0, shifted} - {2'b00, dsr_reg};
        q_bit   = ~diff[TOTAL_W];
        rem_next = q_bit ? diff[STEP_W-1:0] : shifted[STEP_W-1:0];
    end

    // Control: count the quotient bits and flag the last one.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == CNT_W'(1));
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(TOTAL_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            dsr_reg <= divisor;
            rem_reg <= '0;
            q_reg   <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[TOTAL_W-2:0], 1'b0};
            rem_reg <= rem_next;
            q_reg   <= {q_reg[0], q_bit};
        end
    end

    assign res.done    = done_reg;
    assign res.quot_lo = q_reg;
    assign res.rem     = rem_reg;

endmodule

`default_nettype wire

/* rtl/core/led_matrix_sign_animator.sv */
// ============================================================================
// led_matrix_sign_animator: 7x15 LED sign animator
// Keeps the lamp command, animation phase and phase time, renders three 5x7
// glyphs into a double-buffered frame store and returns one row per word.
// ============================================================================
// Usage:
// - Input channel item/item_valid/item_stall: one word sets a command, advances
//   time or only reads a row. item_stall is high while a word is in work.
// - Result channel result/result_valid/result_stall: exactly one word per
//   input word, in order. The result register holds while result_stall is
//   high; the next input word is still taken and worked on meanwhile, and
//   waits for the register to free before it is reported.
// - Configuration channel cfg_valid/cfg_ready/cfg_index/cfg_data: always
//   ready; write only while the block is idle.
// Path from accept to result: a read, an unchanged command or an advance that
// renders nothing goes from decide straight to report; a command change first
// renders the 7 rows, one per cycle; a phase advance first runs the serial
// divider, which yields one quotient bit per cycle over the 17-bit total, then
// the render. A new word is taken the cycle after the result is registered.
// Reset clears the frame, command, phase and time, and loads the register
// defaults; no clearing pass is needed.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module led_matrix_sign_animator (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              item_valid,
    output      logic              item_stall,
    input  wire lmsa_pkg::item_t   item,
    output      logic              result_valid,
    input  wire logic              result_stall,
    output      lmsa_pkg::result_t result,
    input  wire logic              cfg_valid,
    output      logic              cfg_ready,
    input  wire logic [1:0]        cfg_index,
    input  wire logic [15:0]       cfg_data
);
    import lmsa_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECIDE = 3'd1;
    localparam logic [2:0] S_DIV    = 3'd2;
    localparam logic [2:0] S_RENDER = 3'd3;
    localparam logic [2:0] S_DONE   = 3'd4;

    logic [2:0]          state_reg;
    item_t               item_reg;
    logic [BRIGHT_W-1:0] bright_reg;
    logic [STEP_W-1:0]   turn_reg;
    logic [STEP_W-1:0]   hazard_reg;
    logic [STEP_W-1:0]   wiper_reg;
    logic [3:0]          shown_reg;
    logic [1:0]          phase_reg;
    logic [STEP_W-1:0]   time_reg;
    logic                active_reg;
    logic                changed_reg;
    logic [ROW_W-1:0]    rcnt_reg;
    logic [FRAME_W-1:0]  frame_reg [0:1][0:ROW_COUNT-1];
    result_t             result_reg;
    logic                rvalid_reg;

    logic [3:0]          cmd_clean;
    logic [STEP_W-1:0]   period;
    logic [TOTAL_W-1:0]  total;
    logic                div_start;
    div_res_t            div_res;
    logic [14:0]         glyphs;
    logic [FRAME_W-1:0]  row_draw;
    logic [FRAME_W-1:0]  row_read;
    logic                out_free;
    logic [BRIGHT_W-1:0] bright_in;

    assign item_stall   = (state_reg != S_IDLE);
    assign cfg_ready    = 1'b1;
    assign result_valid = rvalid_reg;
    assign result       = result_reg;
    assign out_free     = !rvalid_reg || !result_stall;
    assign bright_in    = cfg_data[BRIGHT_W-1:0];

    // Command cleanup, step period and time total.
    always_comb
    begin
        cmd_clean = (item_reg.lamp_command >= CMD_LIMIT) ? CMD_OFF : item_reg.lamp_command;
        unique case (shown_reg) inside
            CMD_LEFT, CMD_RIGHT: period = turn_reg;
            CMD_HAZARD:          period = hazard_reg;
            CMD_WIPER:           period = wiper_reg;
            default:             period = '0;
        endcase
        total = {1'b0, time_reg} + {1'b0, item_reg.delta_ms};
    end

    assign div_start = (state_reg == S_DECIDE) && (item_reg.action == ACT_ADVANCE)
                       && (period != '0) && !(total < {1'b0, period});

    lmsa_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (total),
        .divisor  (period),
        .res      (div_res)
    );

    // Row being drawn and row being read.
    always_comb
    begin
        glyphs   = pick_glyphs(shown_reg, phase_reg);
        row_draw = {GLYPH_ROM[glyphs[14:10]][rcnt_reg],
                    GLYPH_ROM[glyphs[9:5]][rcnt_reg],
                    GLYPH_ROM[glyphs[4:0]][rcnt_reg]};
        if (item_reg.row_index < ROW_W'(ROW_COUNT))
        begin
            row_read = frame_reg[active_reg][item_reg.row_index];
        end
        else
        begin
            row_read = '0;
        end
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bright_reg <= BRIGHT_RESET;
            turn_reg   <= TURN_RESET;
            hazard_reg <= HAZARD_RESET;
            wiper_reg  <= WIPER_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_BRIGHT: bright_reg <= (bright_in > BRIGHT_MAX) ? BRIGHT_MAX : bright_in;
                REG_TURN:   turn_reg   <= cfg_data;
                REG_HAZARD: hazard_reg <= cfg_data;
                REG_WIPER:  wiper_reg  <= cfg_data;
                default:    bright_reg <= bright_reg;
            endcase
        end
    end

    // Captured input word.
    always_ff @(posedge clk)
    begin
        if (item_valid && !item_stall)
        begin
            item_reg <= item;
        end
    end

    // Sequencer: decide, divide, render, report.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            shown_reg   <= CMD_OFF;
            phase_reg   <= '0;
            time_reg    <= '0;
            active_reg  <= 1'b0;
            changed_reg <= 1'b0;
            rcnt_reg    <= '0;
            rvalid_reg  <= 1'b0;
            result_reg  <= '0;
            for (int b = 0; b < 2; b++)
            begin
                for (int r = 0; r < ROW_COUNT; r++)
                begin
                    frame_reg[b][r] <= '0;
                end
            end
        end
        else
        begin
            // The report state loads the register itself when it frees.
            if (rvalid_reg && !result_stall && (state_reg != S_DONE))
            begin
                rvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (item_valid)
                    begin
                        state_reg   <= S_DECIDE;
                        changed_reg <= 1'b0;
                    end
                end
                S_DECIDE:
                begin
                    rcnt_reg  <= '0;
                    state_reg <= S_DONE;
                    if (item_reg.action == ACT_SET)
                    begin
                        if (cmd_clean != shown_reg)
                        begin
                            shown_reg   <= cmd_clean;
                            phase_reg   <= '0;
                            time_reg    <= '0;
                            changed_reg <= 1'b1;
                            state_reg   <= S_RENDER;
                        end
                    end
                    else if (item_reg.action == ACT_ADVANCE && period != '0)
                    begin
                        if (total < {1'b0, period})
                        begin
                            time_reg <= total[STEP_W-1:0];
                        end
                        else
                        begin
                            state_reg <= S_DIV;
                        end
                    end
                end
                S_DIV:
                begin
                    if (div_res.done)
                    begin
                        time_reg    <= div_res.rem;
                        changed_reg <= 1'b1;
                        state_reg   <= S_RENDER;
                        if (shown_reg == CMD_HAZARD)
                        begin
                            phase_reg <= {1'b0, phase_reg[0] ^ div_res.quot_lo[0]};
                        end
                        else
                        begin
                            phase_reg <= phase_reg + div_res.quot_lo;
                        end
                    end
                end
                S_RENDER:
                begin
                    // Draw into the hidden half, then swap halves.
                    frame_reg[~active_reg][rcnt_reg] <= row_draw;
                    rcnt_reg <= rcnt_reg + ROW_W'(1);
                    if (rcnt_reg == ROW_W'(ROW_COUNT - 1))
                    begin
                        active_reg <= ~active_reg;
                        state_reg  <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    if (out_free)
                    begin
                        result_reg.row_bits        <= row_read;
                        result_reg.current_command <= shown_reg;
                        result_reg.current_phase   <= phase_reg;
                        result_reg.frame_changed   <= changed_reg;
                        result_reg.brightness_out  <= bright_reg;
                        rvalid_reg                 <= 1'b1;
                        state_reg                  <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // A new result word only comes out of the report state.
    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rvalid_reg) |-> $past(state_reg == S_DONE))
        else $error("result raised outside the report state");

    // The divider finishes only while the sequencer waits for it.
    a_div_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_res.done |-> (state_reg == S_DIV))
        else $error("divider finished outside the divide state");

    // The shown command is always a known one.
    a_cmd_known: assert property (@(posedge clk) disable iff (!rst_n)
        shown_reg < CMD_LIMIT)
        else $error("shown command out of range");

    // Hazard blinks over two phases only.
    a_hazard_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (shown_reg == CMD_HAZARD) |-> (phase_reg[1] == 1'b0))
        else $error("hazard phase out of range");

endmodule

`default_nettype wire
